// File: sv/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property every clock, quiet during reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// File: sv/ppu_pkg.sv
// types and constants of the picture unit cpu register port
package ppu_pkg;

    typedef enum logic [0:0]
    {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef enum logic [1:0]
    {
        RK_SPRITE,
        RK_NAME,
        RK_PALETTE
    } rkind_t;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [15:0] ADDR_CTRL     = 16'h2000;
    localparam logic [15:0] ADDR_MASK     = 16'h2001;
    localparam logic [15:0] ADDR_STATUS   = 16'h2002;
    localparam logic [15:0] ADDR_OAM_ADDR = 16'h2003;
    localparam logic [15:0] ADDR_OAM_DATA = 16'h2004;
    localparam logic [15:0] ADDR_SCROLL   = 16'h2005;
    localparam logic [15:0] ADDR_VADDR    = 16'h2006;
    localparam logic [15:0] ADDR_VDATA    = 16'h2007;
    localparam logic [15:0] ADDR_DMA      = 16'h4014;

    localparam logic [15:0] VA_NAME_BASE = 16'h2000;
    localparam logic [15:0] VA_PAL_BASE  = 16'h3F00;
    localparam logic [15:0] VA_TOP       = 16'h4000;

    localparam logic [7:0] STATUS_RESET = 8'hA0;

    localparam int SPRITE_BYTES  = 256;
    localparam int NAME_BYTES    = 2048;
    localparam int PALETTE_BYTES = 32;

    typedef struct packed
    {
        logic        cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  pattern_byte;
    } req_t;

    typedef struct packed
    {
        logic [7:0]  read_data;
        logic [15:0] video_addr;
        logic [2:0]  fine_scroll_x;
        logic [7:0]  control_value;
        logic [7:0]  mask_value;
    } rsp_t;

endpackage

// File: sv/ppu_if.sv
// valid/ready channel interfaces for cpu accesses and their results
interface ppu_req_if;
    logic          valid;
    logic          ready;
    ppu_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ppu_rsp_if;
    logic          valid;
    logic          ready;
    ppu_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/ppu_cpu_register_port.sv
// top level of the picture unit cpu register port
// each req transaction is one cpu bus read or write (cmd, addr, data and the
// external pattern byte at the current video address); each one gives exactly
// one rsp transaction carrying the read byte and the video address, fine x,
// control and mask values after the access.
// register accesses need no memory read: the result sits in the output register
// in the cycle after acceptance, and the next transaction may be accepted in
// that cycle. reads of sprite data and video data reads that land in nametable
// or palette space go through the registered read ports of the sprite,
// nametable and palette memories; req.ready is low during the memory read.
// the output register lets a new transaction in while a result waits, as long
// as the receiver takes it in the same cycle; while rsp.ready stays low the
// result holds and req.ready stays low.
// cfg_we/cfg_wdata write the mirroring mode (0 horizontal, 1 vertical).
// reset clears control, mask, scroll and address state and loads status 0xa0;
// memories are not cleared and must be written before they are read.
`include "assert_macros.svh"

module ppu_cpu_register_port
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    ppu_req_if.sink         req,
    ppu_rsp_if.source       rsp
);

    ppu_pkg::state_t state_reg, state_next;
    ppu_pkg::rkind_t rk_reg, rk_next;

    logic        mirror_reg;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  oam_addr_reg, oam_addr_next;
    logic [14:0] taddr_reg, taddr_next;
    logic [15:0] vaddr_reg, vaddr_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  rbuf_reg, rbuf_next;

    logic        out_valid_reg;
    ppu_pkg::rsp_t out_reg, out_next;

    logic [7:0]  spr_mem [ppu_pkg::SPRITE_BYTES];
    logic [7:0]  name_mem [ppu_pkg::NAME_BYTES];
    logic [7:0]  pal_mem [ppu_pkg::PALETTE_BYTES];
    logic [7:0]  spr_rdata_reg, name_rdata_reg, pal_rdata_reg;

    logic        spr_we, name_we, pal_we, spr_re, name_re, pal_re;
    logic [10:0] name_idx;
    logic [4:0]  pal_widx, pal_ridx;
    logic        acc, load;
    logic [7:0]  rd_val;
    logic [15:0] vstep;
    ppu_pkg::req_t q;

    assign q   = req.payload;
    assign acc = req.valid && req.ready;
    assign req.ready = (state_reg == ppu_pkg::ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    assign vstep    = ctrl_reg[2] ? 16'd32 : 16'd1;
    assign name_idx = {mirror_reg ? vaddr_reg[10] : vaddr_reg[11], vaddr_reg[9:0]};
    assign pal_widx = (vaddr_reg[3:0] == 4'd0) ? 5'd0 : vaddr_reg[4:0];
    assign pal_ridx = (vaddr_reg[1:0] == 2'd0) ? 5'd0 : vaddr_reg[4:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppu_pkg::ST_IDLE:
            begin
                if (spr_re || name_re || pal_re)
                begin
                    state_next = ppu_pkg::ST_READ;
                end
            end
            ppu_pkg::ST_READ:
            begin
                state_next = ppu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ppu_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        ctrl_next     = ctrl_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        oam_addr_next = oam_addr_reg;
        taddr_next    = taddr_reg;
        vaddr_next    = vaddr_reg;
        fine_x_next   = fine_x_reg;
        toggle_next   = toggle_reg;
        rbuf_next     = rbuf_reg;
        rk_next       = rk_reg;
        spr_we  = 1'b0;
        name_we = 1'b0;
        pal_we  = 1'b0;
        spr_re  = 1'b0;
        name_re = 1'b0;
        pal_re  = 1'b0;
        load    = 1'b0;
        rd_val  = 8'd0;
        case (state_reg)
            ppu_pkg::ST_IDLE:
            begin
                if (acc && q.cmd == ppu_pkg::CMD_READ)
                begin
                    load = 1'b1;
                    case (q.addr)
                        ppu_pkg::ADDR_STATUS:
                        begin
                            rd_val      = status_reg;
                            status_next = {1'b0, status_reg[6:0]};
                            toggle_next = 1'b0;
                        end
                        ppu_pkg::ADDR_OAM_DATA:
                        begin
                            load    = 1'b0;
                            spr_re  = 1'b1;
                            rk_next = ppu_pkg::RK_SPRITE;
                        end
                        ppu_pkg::ADDR_VDATA:
                        begin
                            vaddr_next = vaddr_reg + vstep;
                            if (vaddr_reg < ppu_pkg::VA_NAME_BASE)
                            begin
                                rd_val    = rbuf_reg;
                                rbuf_next = q.pattern_byte;
                            end
                            else if (vaddr_reg < ppu_pkg::VA_PAL_BASE)
                            begin
                                load    = 1'b0;
                                name_re = 1'b1;
                                rk_next = ppu_pkg::RK_NAME;
                            end
                            else if (vaddr_reg < ppu_pkg::VA_TOP)
                            begin
                                load    = 1'b0;
                                pal_re  = 1'b1;
                                rk_next = ppu_pkg::RK_PALETTE;
                            end
                            else
                            begin
                                rbuf_next = 8'd0;
                            end
                        end
                        default:
                        begin
                            rd_val = 8'd0;
                        end
                    endcase
                end
                else if (acc)
                begin
                    load = 1'b1;
                    case (q.addr)
                        ppu_pkg::ADDR_CTRL:
                        begin
                            ctrl_next  = q.data;
                            taddr_next = {taddr_reg[14:12], q.data[1:0], taddr_reg[9:0]};
                        end
                        ppu_pkg::ADDR_MASK:
                        begin
                            mask_next = q.data;
                        end
                        ppu_pkg::ADDR_OAM_ADDR:
                        begin
                            oam_addr_next = q.data;
                        end
                        ppu_pkg::ADDR_OAM_DATA, ppu_pkg::ADDR_DMA:
                        begin
                            spr_we        = 1'b1;
                            oam_addr_next = oam_addr_reg + 8'd1;
                        end
                        ppu_pkg::ADDR_SCROLL:
                        begin
                            toggle_next = !toggle_reg;
                            if (!toggle_reg)
                            begin
                                taddr_next  = {taddr_reg[14:5], q.data[7:3]};
                                fine_x_next = q.data[2:0];
                            end
                            else
                            begin
                                taddr_next = {q.data[2:0], taddr_reg[11:10], q.data[7:3],
                                              taddr_reg[4:0]};
                            end
                        end
                        ppu_pkg::ADDR_VADDR:
                        begin
                            toggle_next = !toggle_reg;
                            if (!toggle_reg)
                            begin
                                taddr_next = {1'b0, q.data[5:0], taddr_reg[7:0]};
                            end
                            else
                            begin
                                taddr_next = {taddr_reg[14:8], q.data};
                                vaddr_next = {1'b0, taddr_reg[14:8], q.data};
                            end
                        end
                        ppu_pkg::ADDR_VDATA:
                        begin
                            vaddr_next = vaddr_reg + vstep;
                            if (vaddr_reg >= ppu_pkg::VA_NAME_BASE
                                && vaddr_reg < ppu_pkg::VA_PAL_BASE)
                            begin
                                name_we = 1'b1;
                            end
                            else if (vaddr_reg >= ppu_pkg::VA_PAL_BASE
                                     && vaddr_reg < ppu_pkg::VA_TOP)
                            begin
                                pal_we = 1'b1;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ppu_pkg::ST_READ:
            begin
                load = 1'b1;
                case (rk_reg)
                    ppu_pkg::RK_SPRITE:
                    begin
                        rd_val = spr_rdata_reg;
                    end
                    ppu_pkg::RK_NAME:
                    begin
                        rd_val    = rbuf_reg;
                        rbuf_next = name_rdata_reg;
                    end
                    ppu_pkg::RK_PALETTE:
                    begin
                        rd_val    = pal_rdata_reg;
                        rbuf_next = pal_rdata_reg;
                    end
                    default:
                    begin
                        rd_val = 8'd0;
                    end
                endcase
            end
            default:
            begin
                load = 1'b0;
            end
        endcase

        out_next.read_data     = rd_val;
        out_next.video_addr    = vaddr_next;
        out_next.fine_scroll_x = fine_x_next;
        out_next.control_value = ctrl_next;
        out_next.mask_value    = mask_next;
    end

    // sprite, nametable and palette memories
    always_ff @(posedge clk)
    begin
        if (spr_we)
        begin
            spr_mem[oam_addr_reg] <= q.data;
        end
        if (spr_re)
        begin
            spr_rdata_reg <= spr_mem[oam_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            name_mem[name_idx] <= q.data;
        end
        if (name_re)
        begin
            name_rdata_reg <= name_mem[name_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[pal_widx] <= q.data;
        end
        if (pal_re)
        begin
            pal_rdata_reg <= pal_mem[pal_ridx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppu_pkg::ST_IDLE;
            rk_reg        <= ppu_pkg::RK_SPRITE;
            mirror_reg    <= 1'b0;
            ctrl_reg      <= 8'd0;
            mask_reg      <= 8'd0;
            status_reg    <= ppu_pkg::STATUS_RESET;
            oam_addr_reg  <= 8'd0;
            taddr_reg     <= 15'd0;
            vaddr_reg     <= 16'd0;
            fine_x_reg    <= 3'd0;
            toggle_reg    <= 1'b0;
            rbuf_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rk_reg       <= rk_next;
            ctrl_reg     <= ctrl_next;
            mask_reg     <= mask_next;
            status_reg   <= status_next;
            oam_addr_reg <= oam_addr_next;
            taddr_reg    <= taddr_next;
            vaddr_reg    <= vaddr_next;
            fine_x_reg   <= fine_x_next;
            toggle_reg   <= toggle_next;
            rbuf_reg     <= rbuf_next;
            if (cfg_we)
            begin
                mirror_reg <= cfg_wdata;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_CLK(a_no_accept_in_read, (state_reg == ppu_pkg::ST_READ) |-> !req.ready,
                "transaction accepted during memory read")
    `ASSERT_NEXT(a_read_completes, state_reg == ppu_pkg::ST_READ,
                 state_reg == ppu_pkg::ST_IDLE && out_valid_reg,
                 "memory read did not produce a result")
    `ASSERT_NEXT(a_status_clears_toggle,
                 acc && q.cmd == ppu_pkg::CMD_READ && q.addr == ppu_pkg::ADDR_STATUS,
                 !toggle_reg && !status_reg[7], "status read did not clear toggle")
    `ASSERT_NEXT(a_vdata_steps, acc && q.addr == ppu_pkg::ADDR_VDATA,
                 vaddr_reg == $past(vaddr_reg + vstep),
                 "video address did not step")

endmodule

// File: tb/sv/ppu_access_check.sv
`timescale 1ns / 1ps
// result checker for the cpu register port: predicts every access and compares results
module ppu_access_check
    import ppu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    ppu_req_if   req,
    ppu_rsp_if   rsp,
    output int   outstanding,
    output int   mismatches
);

    logic        vertical_mirror;
    logic [7:0]  ctrl_q;
    logic [7:0]  mask_q;
    logic [7:0]  status_q;
    logic [7:0]  oam_addr;
    logic [14:0] taddr;
    logic [15:0] vaddr;
    logic [2:0]  fine_x;
    logic        second_write;
    logic [7:0]  vbuf;
    logic [7:0]  oam_mem [SPRITE_BYTES];
    logic [7:0]  name_mem [NAME_BYTES];
    logic [7:0]  pal_mem [PALETTE_BYTES];
    rsp_t        pending_results [$];
    int          errs;

    function automatic logic [10:0] name_slot(logic [15:0] va);
        return {vertical_mirror ? va[10] : va[11], va[9:0]};
    endfunction

    function automatic void step_vaddr();
        vaddr = vaddr + (ctrl_q[2] ? 16'd32 : 16'd1);
    endfunction

    function automatic rsp_t cpu_access_result(req_t acc);
        rsp_t       res;
        logic [7:0] rd;
        logic [4:0] pidx;
        rd = 8'h00;
        pidx = vaddr[4:0];
        if (acc.cmd == CMD_READ)
        begin
            case (acc.addr)
                ADDR_STATUS:
                begin
                    rd = status_q;
                    status_q[7] = 1'b0;
                    second_write = 1'b0;
                end
                ADDR_OAM_DATA:
                    rd = oam_mem[oam_addr];
                ADDR_VDATA:
                begin
                    rd = vbuf;
                    if (vaddr < VA_NAME_BASE)
                        vbuf = acc.pattern_byte;
                    else if (vaddr < VA_PAL_BASE)
                        vbuf = name_mem[name_slot(vaddr)];
                    else if (vaddr < VA_TOP)
                        vbuf = (pidx[1:0] == 2'b00) ? pal_mem[0] : pal_mem[pidx];
                    else
                        vbuf = 8'h00;
                    // palette space and the undecoded range above it bypass the read buffer delay
                    if (vaddr >= VA_PAL_BASE)
                        rd = vbuf;
                    step_vaddr();
                end
                default:
                    ;
            endcase
        end
        else
        begin
            case (acc.addr)
                ADDR_CTRL:
                begin
                    ctrl_q = acc.data;
                    taddr[11:10] = acc.data[1:0];
                end
                ADDR_MASK:
                    mask_q = acc.data;
                ADDR_OAM_ADDR:
                    oam_addr = acc.data;
                ADDR_OAM_DATA, ADDR_DMA:
                begin
                    oam_mem[oam_addr] = acc.data;
                    oam_addr = oam_addr + 8'd1;
                end
                ADDR_SCROLL:
                begin
                    if (!second_write)
                    begin
                        taddr[4:0] = acc.data[7:3];
                        fine_x = acc.data[2:0];
                    end
                    else
                    begin
                        taddr[14:12] = acc.data[2:0];
                        taddr[9:5] = acc.data[7:3];
                    end
                    second_write = !second_write;
                end
                ADDR_VADDR:
                begin
                    if (!second_write)
                        taddr[14:8] = {1'b0, acc.data[5:0]};
                    else
                    begin
                        taddr[7:0] = acc.data;
                        vaddr = {1'b0, taddr};
                    end
                    second_write = !second_write;
                end
                ADDR_VDATA:
                begin
                    if (vaddr >= VA_NAME_BASE && vaddr < VA_PAL_BASE)
                        name_mem[name_slot(vaddr)] = acc.data;
                    else if (vaddr >= VA_PAL_BASE && vaddr < VA_TOP)
                    begin
                        pal_mem[pidx] = acc.data;
                        // backdrop entries shadow each other
                        if (pidx == 5'h00)
                            pal_mem[16] = acc.data;
                        else if (pidx == 5'h10)
                            pal_mem[0] = acc.data;
                    end
                    step_vaddr();
                end
                default:
                    ;
            endcase
        end
        res.read_data = rd;
        res.video_addr = vaddr;
        res.fine_scroll_x = fine_x;
        res.control_value = ctrl_q;
        res.mask_value = mask_q;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t seen;
        rsp_t want;
        if (!rst_n)
        begin
            vertical_mirror = 1'b0;
            ctrl_q = 8'h00;
            mask_q = 8'h00;
            status_q = STATUS_RESET;
            oam_addr = 8'h00;
            taddr = 15'h0000;
            vaddr = 16'h0000;
            fine_x = 3'd0;
            second_write = 1'b0;
            vbuf = 8'h00;
            pending_results.delete();
            errs = 0;
            outstanding <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_we)
                vertical_mirror = cfg_wdata;
            if (rsp.valid && rsp.ready)
            begin
                seen = rsp.payload;
                if (pending_results.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: result transaction with nothing pending", $time);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (seen.read_data !== want.read_data
                        || seen.video_addr !== want.video_addr
                        || seen.fine_scroll_x !== want.fine_scroll_x
                        || seen.control_value !== want.control_value
                        || seen.mask_value !== want.mask_value)
                    begin
                        errs++;
                        if (errs <= 10)
                        begin
                            $display("%0t: mismatch, expected rd %h va %h fx %h ctrl %h mask %h",
                                     $time, want.read_data, want.video_addr,
                                     want.fine_scroll_x, want.control_value, want.mask_value);
                            $display("%0t:           got      rd %h va %h fx %h ctrl %h mask %h",
                                     $time, seen.read_data, seen.video_addr,
                                     seen.fine_scroll_x, seen.control_value, seen.mask_value);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
                pending_results.push_back(cpu_access_result(req.payload));
            outstanding <= pending_results.size();
            mismatches <= errs;
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench top for the cpu register port: clock, reset, cpu access stimulus and verdict
module testbench;
    import ppu_pkg::*;

    localparam bit MIRROR_HORIZONTAL = 1'b0;
    localparam bit MIRROR_VERTICAL   = 1'b1;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 950;
    localparam int HIGH_STEPS   = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCT     = 37;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   outstanding;
    int   mismatches;
    bit   steady = 1'b0;
    bit   hold_req = 1'b0;
    int   random_count = 0;

    ppu_req_if req_ch ();
    ppu_rsp_if rsp_ch ();

    ppu_cpu_register_port DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    ppu_access_check access_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    function automatic logic [7:0] random_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic random_cmd();
        return $urandom_range(1) ? CMD_WRITE : CMD_READ;
    endfunction

    // one cpu access, optionally preceded by a gap; valid stays up after the transaction
    task automatic issue(input logic cmd, input logic [15:0] addr, input logic [7:0] data);
        req_t item;
        item.cmd = cmd;
        item.addr = addr;
        item.data = data;
        item.pattern_byte = random_byte();
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [15:0] addr, input logic [7:0] data);
        issue(CMD_WRITE, addr, data);
    endtask

    task automatic read_reg(input logic [15:0] addr);
        issue(CMD_READ, addr, random_byte());
    endtask

    // status read first so the address latch starts on its high byte
    task automatic set_vaddr(input logic [7:0] hi, input logic [7:0] lo);
        read_reg(ADDR_STATUS);
        write_reg(ADDR_VADDR, hi);
        write_reg(ADDR_VADDR, lo);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_mirroring(input bit mode);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_burst();
        int          kind;
        int          n;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [15:0] a;
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            case ($urandom_range(3))
                0: hi = 8'($urandom_range(8'h1F));
                3: hi = 8'h3F;
                default: hi = 8'($urandom_range(8'h3E, 8'h20));
            endcase
            hi[7:6] = 2'($urandom_range(3));
            if ($urandom_range(3) == 0)
            begin
                write_reg(ADDR_CTRL, random_byte());
                random_count++;
            end
            lo = random_byte();
            n = $urandom_range(8, 1);
            // write the run first so later reads only see written entries
            set_vaddr(hi, lo);
            repeat (n)
                write_reg(ADDR_VDATA, random_byte());
            set_vaddr(hi, lo);
            repeat (n)
                issue(random_cmd(), ADDR_VDATA, random_byte());
            random_count += 2 * n + 6;
        end
        else if (kind < 47)
        begin
            write_reg(ADDR_OAM_ADDR, random_byte());
            n = $urandom_range(4, 1);
            repeat (n)
                case ($urandom_range(2))
                    0: read_reg(ADDR_OAM_DATA);
                    1: write_reg(ADDR_OAM_DATA, random_byte());
                    default: write_reg(ADDR_DMA, random_byte());
                endcase
            random_count += n + 1;
        end
        else if (kind < 57)
        begin
            read_reg(ADDR_STATUS);
            write_reg(ADDR_SCROLL, random_byte());
            write_reg(ADDR_SCROLL, random_byte());
            random_count += 3;
        end
        else if (kind < 70)
        begin
            case ($urandom_range(2))
                0: write_reg(ADDR_CTRL, random_byte());
                1: write_reg(ADDR_MASK, random_byte());
                default: read_reg(ADDR_STATUS);
            endcase
            random_count++;
        end
        else if (kind < 82)
        begin
            // half-finished latch sequences
            if ($urandom_range(1))
            begin
                write_reg(ADDR_VADDR, random_byte());
                write_reg(ADDR_VDATA, random_byte());
            end
            else
            begin
                write_reg(ADDR_SCROLL, random_byte());
                write_reg(ADDR_VADDR, random_byte());
            end
            random_count += 2;
        end
        else
        begin
            case ($urandom_range(3))
                0: a = 16'($urandom_range(16'hFFFF));
                1: a = ADDR_CTRL | 16'($urandom_range(15));
                2: a = ADDR_DMA;
                default: a = 16'($urandom_range(16'h401F, 16'h4000));
            endcase
            // video data only as a write, the address may point at an unwritten entry
            if (a == ADDR_VDATA)
                write_reg(a, random_byte());
            else
                issue(random_cmd(), a, random_byte());
            random_count++;
        end
    endtask

    // receiver side
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int target;
        bit hold_done;
        hold_done = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.payload <= '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the palette and sprite memories so any later read is defined
        set_mirroring(MIRROR_VERTICAL);
        set_vaddr(8'h3F, 8'h00);
        repeat (PALETTE_BYTES)
            write_reg(ADDR_VDATA, random_byte());
        write_reg(ADDR_OAM_ADDR, 8'h00);
        repeat (SPRITE_BYTES)
            write_reg(ADDR_DMA, random_byte());

        set_mirroring(MIRROR_HORIZONTAL);
        read_reg(ADDR_STATUS);
        read_reg(ADDR_STATUS);
        write_reg(ADDR_CTRL, 8'hFF);
        write_reg(ADDR_MASK, 8'hFF);
        write_reg(ADDR_SCROLL, 8'hFF);
        write_reg(ADDR_SCROLL, 8'hFF);
        write_reg(ADDR_VADDR, 8'hFF);
        write_reg(ADDR_VADDR, 8'hFF);
        read_reg(ADDR_VDATA);
        write_reg(ADDR_CTRL, 8'h00);
        write_reg(ADDR_MASK, 8'h00);
        set_vaddr(8'h3F, 8'h10);
        write_reg(ADDR_VDATA, 8'hA5);
        set_vaddr(8'h3F, 8'h04);
        read_reg(ADDR_VDATA);
        set_vaddr(8'h2B, 8'hFF);
        write_reg(ADDR_VDATA, random_byte());
        write_reg(ADDR_VDATA, random_byte());
        set_vaddr(8'h2B, 8'hFF);
        read_reg(ADDR_VDATA);
        read_reg(ADDR_VDATA);
        set_vaddr(8'h00, 8'h00);
        write_reg(ADDR_VDATA, 8'hFF);
        read_reg(ADDR_VDATA);
        write_reg(ADDR_STATUS, 8'hFF);
        read_reg(ADDR_CTRL);
        read_reg(ADDR_DMA);
        issue(CMD_WRITE, 16'hFFFF, 8'hFF);
        issue(CMD_READ, 16'h0000, 8'h00);
        write_reg(ADDR_OAM_ADDR, 8'hFF);
        write_reg(ADDR_OAM_DATA, 8'h00);
        read_reg(ADDR_OAM_DATA);

        // step by 32 from the palette top into the undecoded range
        write_reg(ADDR_CTRL, 8'h04);
        set_vaddr(8'h3F, 8'hE0);
        repeat (HIGH_STEPS)
            issue(random_cmd(), ADDR_VDATA, random_byte());
        write_reg(ADDR_CTRL, 8'h00);

        for (int ph = 0; ph < 4; ph++)
        begin
            set_mirroring(ph[0] ? MIRROR_VERTICAL : MIRROR_HORIZONTAL);
            target = RANDOM_ITEMS * (ph + 1) / 4;
            while (random_count < target)
            begin
                steady = (ph == 1) && (random_count >= RANDOM_ITEMS / 4 + 50)
                         && (random_count < RANDOM_ITEMS / 4 + 250);
                if (ph == 2 && !hold_done && random_count > RANDOM_ITEMS / 2 + 100)
                begin
                    hold_req = 1'b1;
                    hold_done = 1'b1;
                end
                random_burst();
            end
            steady = 1'b0;
        end

        settle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: ppu_cpu_register_port.f
+incdir+sv
sv/ppu_pkg.sv
sv/ppu_if.sv
sv/ppu_cpu_register_port.sv
tb/sv/ppu_access_check.sv
tb/sv/testbench.sv
